// ===== rtl/bba_pkg.sv =====
// Shared types and fixed widths for the bitmap block allocator.
// Used by bitmap_block_allocator; depends on nothing else.
package bba_pkg;

	localparam int INDEX_W     = 15;
	localparam int SIZE_W      = 16;
	localparam int INDEX_REACH = 32768;
	localparam logic [SIZE_W-1:0] SIZE_RESET = 16'd32768;

	typedef enum logic [1:0] {
		OP_TEST  = 2'd0,
		OP_SET   = 2'd1,
		OP_CLEAR = 2'd2,
		OP_FIND  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_WIPE,
		ST_IDLE,
		ST_ADDR,
		ST_MOD,
		ST_FIND
	} state_t;

	typedef struct packed {
		op_t                op;
		logic [INDEX_W-1:0] bit_index;
	} item_t;

	typedef struct packed {
		logic               bit_value;
		logic               found;
		logic [INDEX_W-1:0] free_index;
		logic               status;
	} result_t;

endpackage

// ===== rtl/bba_ram.sv =====
// Single-port-write, single-port-read word store with a registered read.
// Holds the allocation bitmap; no package dependency.
module bba_ram #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10,
	parameter int DW    = 32
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/bitmap_block_allocator.sv =====
// Bitmap block allocator: test, set, clear and find-first-clear on a bitmap
// held in bba_ram. Depends on bba_pkg and bba_ram.
//
//  channel   ports                 handshake
//  -------   --------------------  ------------------------------------------
//  command   start, busy, item     word taken when start high and busy low
//  result    done, result          one-cycle strobe, cannot be held off
//  config    size_we, size_wdata   bitmap_size written when size_we high
//
// Test, set and clear step through a multiply for the word address, a memory
// read, then modify and write back. Find reads one word a cycle from word 0
// upward, bounded by the memory's one read port. Reset starts a wipe that
// zeroes the store; busy stays high through it. The result register lets the
// next command be taken in the cycle its predecessor's result is shown.
module bitmap_block_allocator #(
	parameter int BITMAP_BITS = 32768,
	parameter int WORD_BITS   = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  bba_pkg::item_t                item,
	output logic                          done,
	output bba_pkg::result_t              result,
	input  logic                          size_we,
	input  logic [bba_pkg::SIZE_W-1:0]    size_wdata
);

	import bba_pkg::*;

	localparam int STORE_WORDS = (BITMAP_BITS + WORD_BITS - 1) / WORD_BITS;
	localparam int ADDR_W      = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
	localparam int BIT_W       = $clog2(WORD_BITS);
	localparam int SIZE_CAP    = (BITMAP_BITS < INDEX_REACH) ? BITMAP_BITS : INDEX_REACH;
	// Exact quotient for any 15-bit index by reciprocal multiply
	localparam int RECIP_SHIFT = INDEX_W + $clog2(WORD_BITS);
	localparam int RECIP       = ((2 ** RECIP_SHIFT) + WORD_BITS - 1) / WORD_BITS;
	localparam int RECIP_W     = $clog2(RECIP + 1);
	localparam int PROD_W      = INDEX_W + RECIP_W;

	state_t state_q, state_d;

	logic [SIZE_W-1:0]  size_q;
	logic [SIZE_W-1:0]  size_eff;
	logic [ADDR_W-1:0]  wipe_q;

	op_t                op_s1;
	logic [INDEX_W-1:0] idx_s1;
	logic [PROD_W-1:0]  prod_s1;
	logic               oor_s1;
	logic [ADDR_W-1:0]  word_s2;
	logic [BIT_W-1:0]   bit_s2;

	logic [ADDR_W-1:0]  scan_addr_q;
	logic [SIZE_W-1:0]  scan_base_q;
	logic               chk_vld_q;
	logic [SIZE_W-1:0]  chk_base_q;

	logic               done_q;
	result_t            res_q;

	logic [INDEX_W-1:0]   quot;
	logic [INDEX_W-1:0]   rem;
	logic [ADDR_W-1:0]    word_addr;

	logic                 ram_we;
	logic [ADDR_W-1:0]    ram_waddr;
	logic [WORD_BITS-1:0] ram_wdata;
	logic [ADDR_W-1:0]    ram_raddr;
	logic [WORD_BITS-1:0] ram_rdata;

	logic                 ffz_hit;
	logic [BIT_W-1:0]     ffz_pos;
	logic [SIZE_W-1:0]    cand;
	logic                 scan_issue;
	logic                 find_hit;
	logic                 find_miss;
	logic                 accept;
	logic [WORD_BITS-1:0] mod_word;
	logic                 tested_bit;
	logic                 emit;
	result_t              res_d;

	assign size_eff = (size_q > SIZE_W'(SIZE_CAP)) ? SIZE_W'(SIZE_CAP) : size_q;
	assign accept   = start && (state_q == ST_IDLE);

	// word = idx / WORD_BITS, bit = idx % WORD_BITS
	assign quot      = INDEX_W'(prod_s1 >> RECIP_SHIFT);
	assign rem       = idx_s1 - INDEX_W'(quot * INDEX_W'(WORD_BITS));
	assign word_addr = ADDR_W'(quot);

	always_comb begin
		ffz_hit = ~&ram_rdata;
		ffz_pos = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (!ram_rdata[i]) begin
				ffz_pos = BIT_W'(i);
			end
		end
	end

	assign cand       = chk_base_q + SIZE_W'(ffz_pos);
	assign find_hit   = chk_vld_q && ffz_hit;
	assign find_miss  = !find_hit && (scan_base_q >= size_eff);
	assign scan_issue = !find_hit && !find_miss;
	assign tested_bit = ram_rdata[bit_s2];

	always_comb begin
		unique case (op_s1)
			OP_SET:   mod_word = ram_rdata | (WORD_BITS'(1) << bit_s2);
			OP_CLEAR: mod_word = ram_rdata & ~(WORD_BITS'(1) << bit_s2);
			default:  mod_word = ram_rdata;
		endcase
	end

	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_waddr = word_s2;
		ram_wdata = mod_word;
		ram_raddr = word_addr;
		emit      = 1'b0;
		res_d     = '0;
		unique case (state_q)
			ST_WIPE: begin
				ram_we    = 1'b1;
				ram_waddr = wipe_q;
				ram_wdata = '0;
				if (wipe_q == ADDR_W'(STORE_WORDS - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					state_d = (item.op == OP_FIND) ? ST_FIND : ST_ADDR;
				end
			end
			ST_ADDR: begin
				state_d = ST_MOD;
			end
			ST_MOD: begin
				ram_we          = !oor_s1 && (op_s1 == OP_SET || op_s1 == OP_CLEAR);
				emit            = 1'b1;
				res_d.status    = oor_s1;
				res_d.bit_value = !oor_s1 && (op_s1 == OP_TEST) && tested_bit;
				state_d         = ST_IDLE;
			end
			ST_FIND: begin
				ram_raddr = scan_addr_q;
				if (find_hit || find_miss) begin
					emit    = 1'b1;
					state_d = ST_IDLE;
					if (find_hit && (cand < size_eff)) begin
						res_d.found      = 1'b1;
						res_d.free_index = INDEX_W'(cand);
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_WIPE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q    <= SIZE_RESET;
			wipe_q    <= '0;
			done_q    <= 1'b0;
			chk_vld_q <= 1'b0;
		end else begin
			if (size_we) begin
				size_q <= size_wdata;
			end
			if (state_q == ST_WIPE) begin
				wipe_q <= wipe_q + ADDR_W'(1);
			end
			done_q    <= emit;
			chk_vld_q <= (state_q == ST_FIND) && scan_issue;
		end
	end

	// Payload, scan, word address and result registers
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1       <= item.op;
			idx_s1      <= item.bit_index;
			prod_s1     <= PROD_W'(item.bit_index) * PROD_W'(RECIP);
			oor_s1      <= SIZE_W'(item.bit_index) >= size_eff;
			scan_addr_q <= '0;
			scan_base_q <= '0;
		end else if (state_q == ST_FIND && scan_issue) begin
			scan_addr_q <= scan_addr_q + ADDR_W'(1);
			scan_base_q <= scan_base_q + SIZE_W'(WORD_BITS);
			chk_base_q  <= scan_base_q;
		end
		if (state_q == ST_ADDR) begin
			word_s2 <= word_addr;
			bit_s2  <= BIT_W'(rem);
		end
		if (emit) begin
			res_q <= res_d;
		end
	end

	bba_ram #(
		.DEPTH (STORE_WORDS),
		.AW    (ADDR_W),
		.DW    (WORD_BITS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = res_q;

endmodule
